/* hw/rtl/tfpt_pkg.sv */
// Shared widths, constants and interface types of the tent filter pair tap block.
package tfpt_pkg;

   localparam int CENTRE_W = 24;
   localparam int HW_W     = 21;
   localparam int POS_W    = 26;
   localparam int WEIGHT_W = 17;
   localparam int X_W      = 26;
   localparam int FIRST_W  = 10;
   localparam int TEXEL_W  = 11;
   localparam int CNT_W    = 6;
   localparam int FRAC_W   = 16;
   localparam int D_W      = 21;
   localparam int SQ_W     = 42;
   localparam int REM_W    = 44;
   localparam int QUOT_W   = 17;
   localparam int STEP_W   = 5;

   localparam logic [WEIGHT_W-1:0] ONE_Q16  = 17'h10000;
   localparam logic [FRAC_W-1:0]   HALF_Q16 = 16'h8000;
   localparam logic [HW_W-1:0]     HW_RESET = 21'h010000;
   localparam logic [STEP_W-1:0]   CDF_STEPS = 5'd16;
   localparam logic [STEP_W-1:0]   POS_STEPS = 5'd17;

   // One centre after classification: left edge of the first texel pair, first texel, tap count and half-width.
   typedef struct packed {
      logic signed [X_W-1:0]     low;
      logic signed [TEXEL_W-1:0] texel;
      logic [CNT_W-1:0]          count;
      logic [HW_W-1:0]           half_width;
   } job_type;

   typedef struct packed {
      logic              start;
      logic [REM_W-1:0]  den;
      logic [REM_W-1:0]  rem;
      logic [QUOT_W-1:0] feed;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } div_rsp_type;

endpackage

/* hw/rtl/tfpt_front.sv */
// Front end: accepts a request and works out the first texel, left edge and tap count.
module tfpt_front #(
   parameter int MAX_TAPS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tfpt_pkg::CENTRE_W-1:0]  req_centre,
   input  logic [tfpt_pkg::HW_W-1:0]             half_width,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output tfpt_pkg::job_type                     push_job
);

   logic                               valid_ff;
   tfpt_pkg::job_type                  job_ff;
   tfpt_pkg::job_type                  job_in;
   logic signed [tfpt_pkg::X_W-1:0]    centre_x;
   logic signed [tfpt_pkg::X_W-1:0]    start_x;
   logic signed [tfpt_pkg::FIRST_W-1:0] first;
   logic [tfpt_pkg::HW_W:0]            cnt_sum;
   logic [tfpt_pkg::CNT_W-1:0]         raw_cnt;
   logic [tfpt_pkg::CNT_W-1:0]         cnt;

   always_comb begin
      centre_x = tfpt_pkg::X_W'(req_centre);
      start_x  = centre_x - signed'({5'b0, half_width})
                 + signed'({10'b0, tfpt_pkg::HALF_Q16});
      // The upper bits of the Q16 value are its floor.
      first    = start_x[tfpt_pkg::X_W-1:tfpt_pkg::FRAC_W];
      cnt_sum  = {1'b0, half_width} + {6'b0, tfpt_pkg::HALF_Q16};
      raw_cnt  = cnt_sum[tfpt_pkg::HW_W:tfpt_pkg::FRAC_W];
      cnt      = (raw_cnt > tfpt_pkg::CNT_W'(MAX_TAPS)) ? tfpt_pkg::CNT_W'(MAX_TAPS) : raw_cnt;
      job_in.low        = signed'({first, 16'b0}) - signed'({10'b0, tfpt_pkg::HALF_Q16})
                          - centre_x;
      job_in.texel      = tfpt_pkg::TEXEL_W'(first);
      job_in.count      = cnt;
      job_in.half_width = half_width;
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_job   = job_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         // A request that gives no taps is consumed here.
         valid_ff <= req_valid && (cnt != '0);
      end
      if (req_valid && req_ready) begin
         job_ff <= job_in;
      end
   end

endmodule

/* hw/rtl/tfpt_queue.sv */
// Two-entry queue that decouples the front end from the tap sequencer.
module tfpt_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tfpt_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tfpt_pkg::job_type pop_job
);

   tfpt_pkg::job_type mem_ff [2];
   logic              wr_ptr_ff;
   logic              rd_ptr_ff;
   logic [1:0]        fill_ff;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hw/rtl/tfpt_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module tfpt_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tfpt_pkg::div_req_type div_req,
   output tfpt_pkg::div_rsp_type div_rsp
);

   logic [tfpt_pkg::REM_W-1:0]  rem_ff;
   logic [tfpt_pkg::REM_W-1:0]  den_ff;
   logic [tfpt_pkg::QUOT_W-1:0] feed_ff;
   logic [tfpt_pkg::QUOT_W-1:0] quot_ff;
   logic [tfpt_pkg::STEP_W-1:0] steps_ff;
   logic                        busy_ff;
   logic                        done_ff;
   logic [tfpt_pkg::REM_W-1:0]  trial;
   logic                        fits;

   // The caller keeps the starting remainder below the divisor, so the top bit is free.
   assign trial = {rem_ff[tfpt_pkg::REM_W-2:0], feed_ff[tfpt_pkg::QUOT_W-1]};
   assign fits  = (trial >= den_ff);

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && steps_ff == 5'd1) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (div_req.start) begin
         rem_ff   <= div_req.rem;
         den_ff   <= div_req.den;
         feed_ff  <= div_req.feed;
         steps_ff <= div_req.steps;
         quot_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff   <= fits ? (trial - den_ff) : trial;
         quot_ff  <= {quot_ff[tfpt_pkg::QUOT_W-2:0], fits};
         feed_ff  <= {feed_ff[tfpt_pkg::QUOT_W-2:0], 1'b0};
         steps_ff <= steps_ff - 5'd1;
      end
   end

endmodule

/* hw/rtl/tfpt_back.sv */
// Back end: evaluates the tent CDF at texel edges and emits one tap per texel pair.
module tfpt_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  tfpt_pkg::job_type                    pop_job,
   output tfpt_pkg::div_req_type                div_req,
   input  tfpt_pkg::div_rsp_type                div_rsp,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tfpt_pkg::POS_W-1:0]    rsp_tap_position,
   output logic [tfpt_pkg::WEIGHT_W-1:0]        rsp_tap_weight,
   output logic                                 rsp_last_tap
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_H, ST_CDF_PREP, ST_CDF_SQ, ST_CDF_DIV, ST_CDF_WAIT,
      ST_CDF_STORE, ST_POS_PREP, ST_POS_WAIT, ST_EMIT
   } state_type;

   state_type                              state_ff;
   logic signed [tfpt_pkg::X_W-1:0]        x_ff;
   logic signed [tfpt_pkg::TEXEL_W-1:0]    texel_ff;
   logic [tfpt_pkg::CNT_W-1:0]             left_ff;
   logic [tfpt_pkg::HW_W-1:0]              h_ff;
   logic [tfpt_pkg::SQ_W-1:0]              hh_ff;
   logic [tfpt_pkg::D_W-1:0]               d_ff;
   logic [tfpt_pkg::SQ_W-1:0]              dd_ff;
   logic                                   neg_ff;
   logic [1:0]                             stage_ff;
   logic [tfpt_pkg::WEIGHT_W-1:0]          cval_ff;
   logic [tfpt_pkg::WEIGHT_W-1:0]          c0_ff;
   logic [tfpt_pkg::WEIGHT_W-1:0]          c1_ff;
   logic [tfpt_pkg::WEIGHT_W-1:0]          c2_ff;
   logic [tfpt_pkg::WEIGHT_W-1:0]          w_ff;
   logic [tfpt_pkg::QUOT_W-1:0]            pq_ff;
   logic                                   rsp_valid_ff;
   logic signed [tfpt_pkg::POS_W-1:0]      rsp_pos_ff;
   logic [tfpt_pkg::WEIGHT_W-1:0]          rsp_weight_ff;
   logic                                   rsp_last_ff;

   logic signed [tfpt_pkg::X_W-1:0]        h_s;
   logic signed [tfpt_pkg::X_W-1:0]        d_sum;
   logic signed [tfpt_pkg::X_W-1:0]        d_diff;
   logic [tfpt_pkg::WEIGHT_W-1:0]          b_w;
   logic [tfpt_pkg::WEIGHT_W-1:0]          w_w;
   logic signed [tfpt_pkg::POS_W:0]        pos_sum;
   logic                                   out_free;

   always_comb begin
      h_s     = signed'({5'b0, h_ff});
      d_sum   = x_ff + h_s;
      d_diff  = h_s - x_ff;
      // The CDF never decreases, so both weights are non-negative.
      b_w     = c2_ff - c1_ff;
      w_w     = c2_ff - c0_ff;
      pos_sum = signed'({texel_ff, 16'b0}) + signed'({10'b0, pq_ff});
      out_free = !rsp_valid_ff || rsp_ready;

      div_req.start = 1'b0;
      div_req.den   = {1'b0, hh_ff, 1'b0};
      div_req.rem   = {2'b0, dd_ff};
      div_req.feed  = '0;
      div_req.steps = tfpt_pkg::CDF_STEPS;
      case (state_ff)
         ST_CDF_DIV: begin
            div_req.start = 1'b1;
         end
         ST_POS_PREP: begin
            div_req.start = (w_w != '0);
            div_req.den   = {27'b0, w_w};
            div_req.rem   = {28'b0, b_w[tfpt_pkg::WEIGHT_W-1:1]};
            div_req.feed  = {b_w[0], 16'b0};
            div_req.steps = tfpt_pkg::POS_STEPS;
         end
         default: begin
         end
      endcase
   end

   assign pop_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tap_position = rsp_pos_ff;
   assign rsp_tap_weight   = rsp_weight_ff;
   assign rsp_last_tap     = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the emit state a taken tap is replaced by the next one below.
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop_valid) begin
                  x_ff     <= pop_job.low;
                  texel_ff <= pop_job.texel;
                  left_ff  <= pop_job.count;
                  h_ff     <= pop_job.half_width;
                  stage_ff <= 2'd0;
                  state_ff <= ST_MUL_H;
               end
            end
            ST_MUL_H: begin
               hh_ff    <= tfpt_pkg::SQ_W'(h_ff) * tfpt_pkg::SQ_W'(h_ff);
               state_ff <= ST_CDF_PREP;
            end
            ST_CDF_PREP: begin
               neg_ff <= (x_ff <= 0);
               d_ff   <= (x_ff <= 0) ? d_sum[tfpt_pkg::D_W-1:0] : d_diff[tfpt_pkg::D_W-1:0];
               if (x_ff <= -h_s) begin
                  cval_ff  <= '0;
                  state_ff <= ST_CDF_STORE;
               end else if (x_ff >= h_s) begin
                  cval_ff  <= tfpt_pkg::ONE_Q16;
                  state_ff <= ST_CDF_STORE;
               end else begin
                  state_ff <= ST_CDF_SQ;
               end
            end
            ST_CDF_SQ: begin
               dd_ff    <= tfpt_pkg::SQ_W'(d_ff) * tfpt_pkg::SQ_W'(d_ff);
               state_ff <= ST_CDF_DIV;
            end
            ST_CDF_DIV: begin
               state_ff <= ST_CDF_WAIT;
            end
            ST_CDF_WAIT: begin
               if (div_rsp.done) begin
                  cval_ff  <= neg_ff ? div_rsp.quot : (tfpt_pkg::ONE_Q16 - div_rsp.quot);
                  state_ff <= ST_CDF_STORE;
               end
            end
            ST_CDF_STORE: begin
               x_ff <= x_ff + signed'({10'b0, 16'hFFFF}) + 26'sd1;
               case (stage_ff)
                  2'd0: begin
                     c0_ff    <= cval_ff;
                     stage_ff <= 2'd1;
                     state_ff <= ST_CDF_PREP;
                  end
                  2'd1: begin
                     c1_ff    <= cval_ff;
                     stage_ff <= 2'd2;
                     state_ff <= ST_CDF_PREP;
                  end
                  default: begin
                     c2_ff    <= cval_ff;
                     state_ff <= ST_POS_PREP;
                  end
               endcase
            end
            ST_POS_PREP: begin
               w_ff <= w_w;
               if (w_w == '0) begin
                  pq_ff    <= '0;
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_POS_WAIT;
               end
            end
            ST_POS_WAIT: begin
               if (div_rsp.done) begin
                  pq_ff    <= div_rsp.quot;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_pos_ff    <= pos_sum[tfpt_pkg::POS_W-1:0];
                  rsp_weight_ff <= w_ff;
                  rsp_last_ff   <= (left_ff == 6'd1);
                  if (left_ff == 6'd1) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     // The right edge of this pair is the left edge of the next one.
                     left_ff  <= left_ff - 6'd1;
                     texel_ff <= texel_ff + 11'sd2;
                     c0_ff    <= c2_ff;
                     stage_ff <= 2'd1;
                     state_ff <= ST_CDF_PREP;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

/* hw/rtl/tent_filter_pair_taps.sv */
// Tent filter pair taps: for each centre request the block emits min(round(half_width),
// MAX_TAPS) taps, one per texel pair, in order, with last_tap set on the final one; a
// half-width under one half gives no taps. Each tap needs two tent CDF evaluations (three
// for the first tap of a centre) and one position division (none for a zero weight), all
// on a single shared bit-serial divider; an edge outside the tent needs no division.
// The front end and a two-entry queue take further requests while the back end works,
// and an output register lets the back end go on while a tap waits to be taken. Write
// the half-width only while the block is idle.
module tent_filter_pair_taps #(
   parameter int MAX_TAPS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tfpt_pkg::CENTRE_W-1:0] req_centre,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tfpt_pkg::POS_W-1:0]    rsp_tap_position,
   output logic [tfpt_pkg::WEIGHT_W-1:0]        rsp_tap_weight,
   output logic                                 rsp_last_tap,
   input  logic                                 csr_write_enable,
   input  logic [tfpt_pkg::HW_W-1:0]            csr_write_data
);

   logic [tfpt_pkg::HW_W-1:0] half_width_ff;
   logic                      push_valid;
   logic                      push_ready;
   tfpt_pkg::job_type         push_job;
   logic                      pop_valid;
   logic                      pop_ready;
   tfpt_pkg::job_type         pop_job;
   tfpt_pkg::div_req_type     div_req;
   tfpt_pkg::div_rsp_type     div_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= tfpt_pkg::HW_RESET;
      end else if (csr_write_enable) begin
         half_width_ff <= csr_write_data;
      end
   end

   tfpt_front #(
      .MAX_TAPS(MAX_TAPS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_centre (req_centre),
      .half_width (half_width_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   tfpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   tfpt_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   tfpt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_job          (pop_job),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_tap_position (rsp_tap_position),
      .rsp_tap_weight   (rsp_tap_weight),
      .rsp_last_tap     (rsp_last_tap)
   );

endmodule
